@@ rtl/go_to_goal_command_planner_macros.svh @@
// Assertion helpers for the go-to-goal command planner.
`ifndef GO_TO_GOAL_COMMAND_PLANNER_MACROS_SVH
`define GO_TO_GOAL_COMMAND_PLANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GGP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ggp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GGP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ggp assertion failed");

`endif

@@ rtl/ggp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggp_pkg
// Types, constants and the arctangent table of the go-to-goal planner.
// ----------------------------------------------------------------------------
package ggp_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 16;

  localparam int XW = 44;  // CORDIC x/y width (17-bit delta scaled by 2^24 plus gain)
  localparam int ZW = 25;  // CORDIC angle width, Q.20 radians
  localparam int NW = 36;  // radicand width, 4 * (dx^2 + dy^2)
  localparam int RW = 18;  // square root width

  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;
  localparam logic signed [ZW-1:0] PI_Q20    = 25'sd3294199;

  typedef enum logic [1:0] {
    REG_GOAL_X       = 2'd0,
    REG_GOAL_Y       = 2'd1,
    REG_GOAL_HEADING = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
  } pose_t;

  typedef struct packed {
    logic signed [16:0] turn_to_goal;
    logic        [16:0] travel_distance;
    logic signed [15:0] final_turn;
  } cmd_t;

  // Contents of one cell of the chain.
  typedef struct packed {
    logic               valid;
    logic               at_goal;
    logic               axis;
    logic signed [15:0] axis_bearing;
    logic signed [15:0] heading;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [NW-1:0]      rem;
    logic [RW-1:0]      root;
  } cell_t;

  // round(atan(2^-i) * 2^20)
  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 25'sd823550;
      1:  v = 25'sd486170;
      2:  v = 25'sd256879;
      3:  v = 25'sd130396;
      4:  v = 25'sd65451;
      5:  v = 25'sd32757;
      6:  v = 25'sd16383;
      7:  v = 25'sd8192;
      8:  v = 25'sd4096;
      9:  v = 25'sd2048;
      10: v = 25'sd1024;
      11: v = 25'sd512;
      12: v = 25'sd256;
      13: v = 25'sd128;
      14: v = 25'sd64;
      15: v = 25'sd32;
      16: v = 25'sd16;
      17: v = 25'sd8;
      18: v = 25'sd4;
      19: v = 25'sd2;
      20: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ggp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggp_cell
// One cell: a vectoring CORDIC step and a square root digit, each if IDX fits.
// ----------------------------------------------------------------------------
module ggp_cell import ggp_pkg::*; #(
  parameter int IDX              = 0,
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  cell_t d,
  output cell_t q
);

  logic signed [XW-1:0] x_n, y_n;
  logic signed [ZW-1:0] z_n;
  logic [NW-1:0]        rem_n;
  logic [RW-1:0]        root_n;
  cell_t                q_next;

  generate
    if (IDX < ANGLE_ITERATIONS) begin : g_cordic
      logic signed [XW-1:0] xs, ys;
      always_comb begin
        xs = d.x >>> IDX;
        ys = d.y >>> IDX;
        if (d.y > 0) begin
          x_n = d.x + ys;
          y_n = d.y - xs;
          z_n = d.z + atan_q20(IDX);
        end else begin
          x_n = d.x - ys;
          y_n = d.y + xs;
          z_n = d.z - atan_q20(IDX);
        end
      end
    end else begin : g_no_cordic
      assign x_n = d.x;
      assign y_n = d.y;
      assign z_n = d.z;
    end

    if (IDX < RW) begin : g_sqrt
      localparam int SB = RW - 1 - IDX;
      logic [NW-1:0] trial;
      always_comb begin
        // (root + 2^SB)^2 - root^2, with root holding only bits above SB
        trial = (NW'(d.root) << (SB + 1)) + (NW'(1) << (2 * SB));
        if (d.rem >= trial) begin
          rem_n  = d.rem - trial;
          root_n = d.root | (RW'(1) << SB);
        end else begin
          rem_n  = d.rem;
          root_n = d.root;
        end
      end
    end else begin : g_no_sqrt
      assign rem_n  = d.rem;
      assign root_n = d.root;
    end
  endgenerate

  always_comb begin
    q_next      = d;
    q_next.x    = x_n;
    q_next.y    = y_n;
    q_next.z    = z_n;
    q_next.rem  = rem_n;
    q_next.root = root_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

@@ rtl/go_to_goal_command_planner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_command_planner
// Rotate-translate-rotate commands from the current pose to a goal pose.
// ----------------------------------------------------------------------------
// Channel   Signals                          Payload
// pose in   in_valid / in_stall / in_data    pose_t  (x, y Q5.11, heading Q3.13)
// cmd out   out_valid / out_stall / out_data cmd_t   (turn, distance, final turn)
// config    cfg_write / cfg_index / cfg_data goal_x, goal_y, goal_heading
//
// One pose transaction is accepted every cycle. The depth of the pipeline is
// set by the chain of cells: each cell does at most one CORDIC step and at
// most one bit of the square root. The whole pipeline moves as one; it holds
// only while a finished command waits at the output under stall, and then
// in_stall is raised. Reset is synchronous and clears the valid bits and the
// goal registers; no pose at the goal position produces a command.
// ----------------------------------------------------------------------------
module go_to_goal_command_planner import ggp_pkg::*; #(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pose_t       in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cmd_t        out_data,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "go_to_goal_command_planner_macros.svh"

  localparam int NCELL = (ANGLE_ITERATIONS > RW) ? ANGLE_ITERATIONS : RW;

  // Configuration registers.
  logic signed [15:0] goal_x, goal_y, goal_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x       <= '0;
      goal_y       <= '0;
      goal_heading <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_GOAL_X:       goal_x       <= cfg_data;
        REG_GOAL_Y:       goal_y       <= cfg_data;
        REG_GOAL_HEADING: goal_heading <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless the output holds a stalled command.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A: deltas from the goal and the at-goal check.
  logic               a_valid, a_at_goal;
  logic signed [16:0] a_dx, a_dy;
  logic signed [15:0] a_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      a_dx      <= 17'(goal_x) - 17'(in_data.pose_x);
      a_dy      <= 17'(goal_y) - 17'(in_data.pose_y);
      a_heading <= in_data.pose_heading;
      a_at_goal <= (in_data.pose_x == goal_x) && (in_data.pose_y == goal_y);
    end
  end

  // Stage B: squares of the deltas.
  logic               b_valid, b_at_goal;
  logic signed [16:0] b_dx, b_dy;
  logic signed [15:0] b_heading;
  logic [33:0]        b_sqx, b_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid   <= a_valid;
      b_at_goal <= a_at_goal;
      b_dx      <= a_dx;
      b_dy      <= a_dy;
      b_heading <= a_heading;
      b_sqx     <= 34'(a_dx * a_dx);
      b_sqy     <= 34'(a_dy * a_dy);
    end
  end

  // Stage C: CORDIC start vector (folded into the right half plane), the
  // exact bearing on the axes, and the radicand 4 * (dx^2 + dy^2).
  cell_t              c_next;
  logic signed [17:0] abs_dx, abs_dy;
  logic signed [XW-1:0] x_ext, y_ext;

  always_comb begin
    if (b_dx < 0) begin
      abs_dx = -18'(b_dx);
      abs_dy = -18'(b_dy);
    end else begin
      abs_dx = 18'(b_dx);
      abs_dy = 18'(b_dy);
    end
    x_ext = XW'(abs_dx);
    y_ext = XW'(abs_dy);

    c_next         = '0;
    c_next.valid   = b_valid;
    c_next.at_goal = b_at_goal;
    c_next.heading = b_heading;
    c_next.axis    = (b_dx == 0) || (b_dy == 0);
    if (b_dy == 0) begin
      c_next.axis_bearing = (b_dx > 0) ? 16'sd0 : PI_Q13;
    end else begin
      c_next.axis_bearing = (b_dy > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
    end
    c_next.x = x_ext <<< 24;
    c_next.y = y_ext <<< 24;
    if (b_dx < 0) begin
      c_next.z = (b_dy > 0) ? PI_Q20 : -PI_Q20;
    end else begin
      c_next.z = '0;
    end
    c_next.rem  = {NW'(b_sqx) + NW'(b_sqy)} << 2;
    c_next.root = '0;
  end

  cell_t chain [0:NCELL];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0] <= c_next;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      ggp_cell #(
        .IDX              (gi),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
      ) u_cell (
        .clk (clk),
        .rst (rst),
        .adv (adv),
        .d   (chain[gi]),
        .q   (chain[gi+1])
      );
    end
  endgenerate

  // Stage E: round the CORDIC angle to Q3.13, saturate, round the distance.
  cell_t              last;
  logic signed [ZW-1:0] z_rnd;
  logic signed [17:0] z_q13;
  logic signed [15:0] bearing_next;
  logic [RW:0]        root_inc;

  logic               e_valid, e_at_goal;
  logic signed [15:0] e_bearing, e_heading;
  logic [16:0]        e_dist;

  always_comb begin
    last  = chain[NCELL];
    z_rnd = (last.z + 25'sd64) >>> 7;
    z_q13 = 18'(z_rnd);
    if (last.axis) begin
      bearing_next = last.axis_bearing;
    end else if (z_q13 > 18'(PI_Q13)) begin
      bearing_next = PI_Q13;
    end else if (z_q13 < 18'(-PI_Q13 + 16'sd1)) begin
      bearing_next = -PI_Q13 + 16'sd1;
    end else begin
      bearing_next = 16'(z_q13);
    end
    root_inc = (RW + 1)'(last.root) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid   <= last.valid;
      e_at_goal <= last.at_goal;
      e_bearing <= bearing_next;
      e_heading <= last.heading;
      e_dist    <= root_inc[17:1];
    end
  end

  // Output stage: the two turns. The final turn is wrapped once into
  // [-pi, pi), which covers every goal heading and bearing.
  logic signed [16:0] fin_raw, fin_wrap;
  cmd_t               out_next;

  always_comb begin
    fin_raw = 17'(goal_heading) - 17'(e_bearing);
    if (fin_raw < -17'(PI_Q13)) begin
      fin_wrap = fin_raw + TWO_PI_Q13;
    end else if (fin_raw >= 17'(PI_Q13)) begin
      fin_wrap = fin_raw - TWO_PI_Q13;
    end else begin
      fin_wrap = fin_raw;
    end
    out_next.turn_to_goal    = 17'(e_bearing) - 17'(e_heading);
    out_next.travel_distance = e_dist;
    out_next.final_turn      = 16'(fin_wrap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_valid && !e_at_goal;
      out_data  <= out_next;
    end
  end

  // A finished pose off the goal always reaches the output.
  `GGP_ASSERT_NEXT(a_result_follows, e_valid && !e_at_goal && adv, out_valid)
  // A command is never made for a zero distance.
  `GGP_ASSERT_SAME(a_dist_nonzero, out_valid, out_data.travel_distance != 17'd0)
  // The final turn is wrapped to at least minus pi.
  `GGP_ASSERT_SAME(a_final_wrapped, out_valid, out_data.final_turn >= -PI_Q13)

endmodule
